@@ sv/bpm_pkg.sv @@
// ----------------------------------------------------------------------------
// bpm_pkg
// Character codes and result class codes for the bracket pair matcher.
// ----------------------------------------------------------------------------
package bpm_pkg;

   localparam logic [7:0] CH_X_LOWER = 8'h78;
   localparam logic [7:0] CH_X_UPPER = 8'h58;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_RANGLE  = 8'h3E;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_LANGLE  = 8'h3C;

   typedef enum logic [1:0] {
      CLS_NONE      = 2'd0,
      CLS_FORBIDDEN = 2'd1,
      CLS_UNPAIRED  = 2'd2,
      CLS_PAIRED    = 2'd3
   } pair_class_type;

endpackage

@@ sv/bracket_pair_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// bracket_pair_matcher_unit
// Dot-bracket structure parser: pairs opening and closing brackets of a
// structure string delivered from its last character to its first.
// ----------------------------------------------------------------------------
// One character is taken per cycle and gives one result beat in the next cycle,
// held in a single result register; a new character is taken whenever that
// register is empty or being emptied. Closing positions are kept on a stack:
// the innermost entry and the one beneath it sit in registers, the rest in a
// single-port-write, single-read memory whose read is issued for the entry
// just beneath the new top, so pushes and pops can follow each other in every
// cycle. A csr_write sets the string length (0 counts as 1, capped at MAX_LEN)
// and restarts the string at that position. There is no clearing pass.
// ----------------------------------------------------------------------------
module bracket_pair_matcher_unit #(
   parameter int MAX_LEN = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [$clog2(MAX_LEN+1)-1:0]       csr_seq_length,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_symbol,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [$clog2(MAX_LEN+1)-1:0]       rsp_position,
   output logic [1:0]                         rsp_pair_class,
   output logic [$clog2(MAX_LEN+1)-1:0]       rsp_partner,
   output logic [$clog2(MAX_LEN+1)-1:0]       rsp_last_close,
   output logic [$clog2(MAX_LEN+1)-1:0]       rsp_pending_count,
   output logic                               rsp_error,
   output logic                               rsp_last
);

   localparam int PosW  = $clog2(MAX_LEN + 1);
   localparam int AddrW = $clog2(MAX_LEN);
   localparam logic [PosW-1:0] MaxPos = PosW'(MAX_LEN);

   logic [PosW-1:0]  seq_len_ff;
   logic [PosW-1:0]  pos_ff, pos_in;
   logic [PosW-1:0]  depth_ff, depth_in;
   logic [PosW-1:0]  top_ff, top_in;
   logic             err_ff, err_in;
   logic             byp_ff, byp_in;
   logic [PosW-1:0]  byp_data_ff, byp_data_in;
   logic [PosW-1:0]  rd_data_ff;
   logic [PosW-1:0]  stack_mem [MAX_LEN];

   logic             rsp_valid_ff;
   logic [PosW-1:0]  rsp_position_ff, rsp_position_in;
   bpm_pkg::pair_class_type rsp_class_ff, rsp_class_in;
   logic [PosW-1:0]  rsp_partner_ff, rsp_partner_in;
   logic [PosW-1:0]  rsp_last_close_ff, rsp_last_close_in;
   logic [PosW-1:0]  rsp_pending_ff, rsp_pending_in;
   logic             rsp_error_ff, rsp_error_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             accept;
   logic [PosW-1:0]  len;
   logic             start;
   logic [PosW-1:0]  pos, depth0, depth1, depth2, top1, top2, next0, next1, top_out;
   logic             err0, err1;
   logic             is_close, is_open;
   logic             push_wr;
   logic [AddrW-1:0] wr_addr, rd_addr;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      len = seq_len_ff;
      if (seq_len_ff == '0) begin
         len = PosW'(1);
      end else if (seq_len_ff > MaxPos) begin
         len = MaxPos;
      end
   end

   always_comb begin
      is_close = req_symbol inside {bpm_pkg::CH_RPAREN, bpm_pkg::CH_RBRACK,
                                    bpm_pkg::CH_RBRACE, bpm_pkg::CH_RANGLE};
      is_open  = req_symbol inside {bpm_pkg::CH_LPAREN, bpm_pkg::CH_LBRACK,
                                    bpm_pkg::CH_LBRACE, bpm_pkg::CH_LANGLE};

      start  = (pos_ff == '0) || (pos_ff > len);
      pos    = start ? len : pos_ff;
      depth0 = start ? '0 : depth_ff;
      err0   = start ? 1'b0 : err_ff;
      next0  = byp_ff ? byp_data_ff : rd_data_ff;

      rsp_class_in = bpm_pkg::CLS_NONE;
      if (req_symbol == bpm_pkg::CH_X_LOWER || req_symbol == bpm_pkg::CH_X_UPPER) begin
         rsp_class_in = bpm_pkg::CLS_FORBIDDEN;
      end else if (req_symbol == bpm_pkg::CH_DOT) begin
         rsp_class_in = bpm_pkg::CLS_UNPAIRED;
      end

      depth1      = depth0;
      top1        = top_ff;
      next1       = next0;
      err1        = err0;
      push_wr     = 1'b0;
      byp_in      = byp_ff;
      byp_data_in = byp_data_ff;
      if (is_close) begin
         if (depth0 < MaxPos) begin
            depth1      = depth0 + PosW'(1);
            top1        = pos;
            next1       = top_ff;
            push_wr     = (depth0 != '0);
            byp_in      = 1'b1;
            byp_data_in = top_ff;
         end else begin
            err1 = 1'b1;
         end
      end

      top_out        = (depth1 != '0) ? top1 : len;
      rsp_pending_in = depth1;
      rsp_partner_in = '0;
      depth2         = depth1;
      top2           = top1;
      if (is_open) begin
         if (depth1 != '0) begin
            rsp_class_in   = bpm_pkg::CLS_PAIRED;
            rsp_partner_in = top_out;
            depth2         = depth1 - PosW'(1);
            top2           = next1;
            byp_in         = 1'b0;
         end else begin
            err1 = 1'b1;
         end
      end

      if (pos == PosW'(1) && depth2 != '0) begin
         err1 = 1'b1;
      end

      rsp_position_in   = pos;
      rsp_last_close_in = top_out;
      rsp_error_in      = err1;
      rsp_last_in       = (pos == PosW'(1));

      pos_in   = accept ? pos - PosW'(1) : pos_ff;
      depth_in = accept ? depth2 : depth_ff;
      top_in   = accept ? top2 : top_ff;
      err_in   = accept ? err1 : err_ff;
      if (!accept) begin
         byp_in      = byp_ff;
         byp_data_in = byp_data_ff;
      end

      wr_addr = AddrW'(depth0 - PosW'(1));
      rd_addr = AddrW'(depth_in - PosW'(2));
   end

   always_ff @(posedge clock) begin
      if (accept && push_wr) begin
         stack_mem[wr_addr] <= top_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff   <= PosW'(1);
         pos_ff       <= '0;
         depth_ff     <= '0;
         err_ff       <= 1'b0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            seq_len_ff <= csr_seq_length;
            pos_ff     <= '0;
         end else begin
            pos_ff <= pos_in;
         end
         depth_ff <= depth_in;
         err_ff   <= err_in;
         byp_ff   <= byp_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      byp_data_ff <= byp_data_in;
      if (accept) begin
         rsp_position_ff   <= rsp_position_in;
         rsp_class_ff      <= rsp_class_in;
         rsp_partner_ff    <= rsp_partner_in;
         rsp_last_close_ff <= rsp_last_close_in;
         rsp_pending_ff    <= rsp_pending_in;
         rsp_error_ff      <= rsp_error_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_pair_class    = rsp_class_ff;
   assign rsp_partner       = rsp_partner_ff;
   assign rsp_last_close    = rsp_last_close_ff;
   assign rsp_pending_count = rsp_pending_ff;
   assign rsp_error         = rsp_error_ff;
   assign rsp_last          = rsp_last_ff;

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= MaxPos)
      else $error("stack depth beyond capacity");

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted character gave no result beat");

   a_partner_only_paired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_class_ff != bpm_pkg::CLS_PAIRED |-> rsp_partner_ff == '0)
      else $error("partner set on unpaired result");

   a_last_at_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_position_ff == PosW'(1))
      else $error("end mark away from position one");

   a_paired_pops: assert property (@(posedge clock) disable iff (reset)
      accept && rsp_class_in == bpm_pkg::CLS_PAIRED |=> depth_ff == $past(depth1) - PosW'(1))
      else $error("pairing did not pop the stack");

endmodule
